// File: sv/rf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rf_pkg;

  localparam int COEF_W    = 32;
  localparam int PRICE_W   = 31;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HP_GAIN  = 3'd0,
    CFG_HP_FB1   = 3'd1,
    CFG_HP_FB2   = 3'd2,
    CFG_SM_C1    = 3'd3,
    CFG_SM_C2    = 3'd4,
    CFG_SM_C3    = 3'd5
  } cfg_idx_t;

  // Q4.28 coefficients loaded at reset
  localparam logic signed [COEF_W-1:0] RST_HP_GAIN = 32'sd245201025;
  localparam logic signed [COEF_W-1:0] RST_HP_FB1  = 32'sd489350320;
  localparam logic signed [COEF_W-1:0] RST_HP_FB2  = 32'sd223020204;
  localparam logic signed [COEF_W-1:0] RST_SM_C1   = 32'sd67947725;
  localparam logic signed [COEF_W-1:0] RST_SM_C2   = 32'sd310893617;
  localparam logic signed [COEF_W-1:0] RST_SM_C3   = -32'sd110405892;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HP_M0,
    ST_HP_M1,
    ST_HP_M2,
    ST_HP_ACC,
    ST_HP_RND,
    ST_SM_M0,
    ST_SM_M1,
    ST_SM_M2,
    ST_SM_ACC,
    ST_SM_RND
  } state_t;

  typedef enum logic [2:0] {
    OP_GAIN_D2,
    OP_FB1_HH0,
    OP_FB2_HH1,
    OP_C1_HSUM,
    OP_C2_RH0,
    OP_C3_RH1
  } op_sel_t;

  typedef struct packed {
    logic    load_in;
    op_sel_t op_sel;
    logic    acc_clr;
    logic    acc_add;
    logic    rnd_hp;
    logic    finish;
  } rf_cmd_t;

  typedef struct packed {
    logic out_free;
  } rf_status_t;

endpackage

`default_nettype wire

// File: sv/rf_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rf_in_if;
  logic                         valid;
  logic                         ready;
  logic [rf_pkg::PRICE_W-1:0]   price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

interface rf_out_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] roofing_value;
  logic signed [SAMPLE_WIDTH-1:0] highpass_value;
  logic                           saturated;

  modport source (output valid, output roofing_value, output highpass_value,
                  output saturated, input ready);
  modport sink   (input valid, input roofing_value, input highpass_value,
                  input saturated, output ready);
endinterface

`default_nettype wire

// File: sv/roofing_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Roofing filter: a two-pole high-pass stage followed by a two-pole
// smoother, one result word per price word. Prices are unsigned Q15.16,
// results signed Q16.16 clamped to SAMPLE_WIDTH bits; coefficients are
// signed Q4.28 (COEF_FRAC_BITS fraction bits) written on the cfg port;
// the user must write them only while no sample is in flight, as the block
// itself does not enforce this. Writes to indexes 6 and 7 are dropped.
// The next sample is accepted the cycle after a result is written to the
// output register, so no new sample is taken while one is in flight. The
// schedule is set by the single shared multiplier: three products per
// stage, a step to drain the product register and a step to round and
// clamp, for each of the two stages. A result held by a stalled sink
// delays only the write of the next result.
module roofing_filter_top #(
  parameter int SAMPLE_WIDTH   = 32,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rf_in_if.sink                         in_ch,
  rf_out_if.source                      out_ch,
  input  logic                          cfg_we,
  input  logic [rf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rf_pkg::COEF_W-1:0]     cfg_data
);
  import rf_pkg::*;

  rf_cmd_t    cmd;
  rf_status_t status;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  rf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rf_dpath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_price           (in_ch.price),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_roofing_value  (out_ch.roofing_value),
    .out_highpass_value (out_ch.highpass_value),
    .out_saturated      (out_ch.saturated)
  );

endmodule

`default_nettype wire

// File: sv/rf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rf_pkg::rf_status_t status,
  output rf_pkg::rf_cmd_t    cmd
);
  import rf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // One shared multiplier: three products per stage, a step to drain
  // the product register, and a step to round and clamp.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.op_sel = OP_GAIN_D2;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // no word is taken while reset is held
        in_ready = rst_n;
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_HP_M0;
        end
      end
      ST_HP_M0: begin
        cmd.op_sel  = OP_GAIN_D2;
        cmd.acc_clr = 1'b1;
        state_nxt   = ST_HP_M1;
      end
      ST_HP_M1: begin
        cmd.op_sel  = OP_FB1_HH0;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_HP_M2;
      end
      ST_HP_M2: begin
        cmd.op_sel  = OP_FB2_HH1;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_HP_ACC;
      end
      ST_HP_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_HP_RND;
      end
      ST_HP_RND: begin
        cmd.rnd_hp = 1'b1;
        state_nxt  = ST_SM_M0;
      end
      ST_SM_M0: begin
        cmd.op_sel  = OP_C1_HSUM;
        cmd.acc_clr = 1'b1;
        state_nxt   = ST_SM_M1;
      end
      ST_SM_M1: begin
        cmd.op_sel  = OP_C2_RH0;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_SM_M2;
      end
      ST_SM_M2: begin
        cmd.op_sel  = OP_C3_RH1;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_SM_ACC;
      end
      ST_SM_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_SM_RND;
      end
      ST_SM_RND: begin
        // hold here while the previous word still sits in the output register
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_HP_M0))
    else $error("accepted word did not start the high-pass pass");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> status.out_free)
    else $error("result written over a pending output word");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (state_r == ST_IDLE))
    else $error("sequencer did not return to idle after a result");

endmodule

`default_nettype wire

// File: sv/rf_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module rf_dpath #(
  parameter int SAMPLE_WIDTH   = 32,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rf_pkg::rf_cmd_t                     cmd,
  output rf_pkg::rf_status_t                  status,
  input  logic [rf_pkg::PRICE_W-1:0]          in_price,
  input  logic                                cfg_we,
  input  logic [rf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rf_pkg::COEF_W-1:0]           cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      out_roofing_value,
  output logic signed [SAMPLE_WIDTH-1:0]      out_highpass_value,
  output logic                                out_saturated
);
  import rf_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int F     = COEF_FRAC_BITS;
  localparam int D2_W  = PRICE_W + 3;
  localparam int A_W   = COEF_W + 1;
  localparam int B_W   = (SW + 1 > D2_W) ? SW + 1 : D2_W;
  localparam int P_W   = A_W + B_W;
  localparam int ACC_W = P_W + 2;

  localparam logic signed [ACC_W-1:0] HALF_HP =
    {{(ACC_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF_SM =
    {{(ACC_W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [ACC_W-1:0] SMAX_A = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN_A = {{(ACC_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0]    SMAX_S = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]    SMIN_S = {1'b1, {(SW-1){1'b0}}};

  // coefficients
  logic signed [COEF_W-1:0] gain_r, fb1_r, fb2_r, c1_r, c2_r, c3_r;

  // histories
  logic [PRICE_W-1:0]   ph0_r, ph1_r;
  logic signed [SW-1:0] hh0_r, hh1_r, rh0_r, rh1_r;

  // working registers
  logic [PRICE_W-1:0]      p_r;
  logic signed [D2_W-1:0]  d2_r;
  logic signed [D2_W-1:0]  d2_nxt;
  logic signed [SW-1:0]    hp_r;
  logic                    clip_hp_r;
  logic signed [P_W-1:0]   prod_r;
  logic signed [P_W-1:0]   prod_nxt;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [SW-1:0]    out_roof_r;
  logic signed [SW-1:0]    out_hp_r;
  logic                    out_sat_r;

  logic signed [A_W-1:0]   a_op;
  logic signed [B_W-1:0]   b_op;
  logic signed [SW:0]      hsum;
  logic signed [ACC_W-1:0] rnd_add;
  logic signed [ACC_W-1:0] rnd_shr;
  logic                    sat_hi;
  logic                    sat_lo;
  logic                    rnd_clip;
  logic signed [SW-1:0]    rnd_val;

  // second difference, taken against the histories before this sample
  assign d2_nxt = $signed({3'b000, in_price}) - $signed({2'b00, ph0_r, 1'b0})
                + $signed({3'b000, ph1_r});

  assign hsum = (SW + 1)'(hp_r) + (SW + 1)'(hh0_r);

  always_comb begin
    a_op = '0;
    b_op = '0;
    case (cmd.op_sel)
      OP_GAIN_D2: begin
        a_op = A_W'(gain_r);
        b_op = B_W'(d2_r);
      end
      OP_FB1_HH0: begin
        a_op = A_W'(fb1_r);
        b_op = B_W'(hh0_r);
      end
      OP_FB2_HH1: begin
        a_op = -A_W'(fb2_r);
        b_op = B_W'(hh1_r);
      end
      OP_C1_HSUM: begin
        a_op = A_W'(c1_r);
        b_op = B_W'(hsum);
      end
      // smoother feedback taps are doubled; the halved sum is folded
      // into the extra shift bit at rounding
      OP_C2_RH0: begin
        a_op = {c2_r, 1'b0};
        b_op = B_W'(rh0_r);
      end
      OP_C3_RH1: begin
        a_op = {c3_r, 1'b0};
        b_op = B_W'(rh1_r);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign prod_nxt = a_op * b_op;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.acc_clr) begin
      acc_nxt = '0;
    end else if (cmd.acc_add) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  // round to nearest, ties up, then clamp to the sample range
  assign rnd_add  = acc_r + (cmd.rnd_hp ? HALF_HP : HALF_SM);
  assign rnd_shr  = cmd.rnd_hp ? (rnd_add >>> F) : (rnd_add >>> (F + 1));
  assign sat_hi   = rnd_shr > SMAX_A;
  assign sat_lo   = rnd_shr < SMIN_A;
  assign rnd_clip = sat_hi | sat_lo;
  assign rnd_val  = sat_hi ? SMAX_S : (sat_lo ? SMIN_S : rnd_shr[SW-1:0]);

  assign out_valid_nxt = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= RST_HP_GAIN;
      fb1_r       <= RST_HP_FB1;
      fb2_r       <= RST_HP_FB2;
      c1_r        <= RST_SM_C1;
      c2_r        <= RST_SM_C2;
      c3_r        <= RST_SM_C3;
      ph0_r       <= '0;
      ph1_r       <= '0;
      hh0_r       <= '0;
      hh1_r       <= '0;
      rh0_r       <= '0;
      rh1_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HP_GAIN: gain_r <= cfg_data;
          CFG_HP_FB1:  fb1_r  <= cfg_data;
          CFG_HP_FB2:  fb2_r  <= cfg_data;
          CFG_SM_C1:   c1_r   <= cfg_data;
          CFG_SM_C2:   c2_r   <= cfg_data;
          CFG_SM_C3:   c3_r   <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.finish) begin
        ph1_r <= ph0_r;
        ph0_r <= p_r;
        hh1_r <= hh0_r;
        hh0_r <= hp_r;
        rh1_r <= rh0_r;
        rh0_r <= rnd_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (cmd.load_in) begin
      p_r  <= in_price;
      d2_r <= d2_nxt;
    end
    if (cmd.rnd_hp) begin
      hp_r      <= rnd_val;
      clip_hp_r <= rnd_clip;
    end
    if (cmd.finish) begin
      out_roof_r <= rnd_val;
      out_hp_r   <= hp_r;
      out_sat_r  <= clip_hp_r | rnd_clip;
    end
  end

  assign status.out_free    = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_roofing_value  = out_roof_r;
  assign out_highpass_value = out_hp_r;
  assign out_saturated      = out_sat_r;

  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished result not presented");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.finish))
    else $error("output word appeared without a finished result");

  a_hp_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rnd_hp && rnd_clip) |=> (hp_r == SMAX_S || hp_r == SMIN_S))
    else $error("clipped high-pass value not at a range limit");

endmodule

`default_nettype wire
